>>> hdl/y86_execute_stage_top_assert.svh
// ----------------------------------------------------------------------------
// y86 execute stage assertion macros
// concurrent checks on the rising edge of i_clk, switched off in reset
// ----------------------------------------------------------------------------
`ifndef Y86_EXECUTE_STAGE_TOP_ASSERT_SVH
`define Y86_EXECUTE_STAGE_TOP_ASSERT_SVH

// same-cycle implication
`define Y86ES_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("y86 execute stage check failed");

// next-cycle implication
`define Y86ES_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("y86 execute stage check failed");

`endif

>>> hdl/y86es_pkg.sv
// ----------------------------------------------------------------------------
// y86es_pkg
// types, codes and constants shared by the y86 execute stage
// ----------------------------------------------------------------------------
`default_nettype none

package y86es_pkg;

    // instruction codes
    localparam logic [3:0] IC_HALT  = 4'd0;
    localparam logic [3:0] IC_NOP   = 4'd1;
    localparam logic [3:0] IC_CMOV  = 4'd2;
    localparam logic [3:0] IC_IRMOV = 4'd3;
    localparam logic [3:0] IC_RMMOV = 4'd4;
    localparam logic [3:0] IC_MRMOV = 4'd5;
    localparam logic [3:0] IC_OPQ   = 4'd6;
    localparam logic [3:0] IC_JXX   = 4'd7;
    localparam logic [3:0] IC_CALL  = 4'd8;
    localparam logic [3:0] IC_RET   = 4'd9;
    localparam logic [3:0] IC_PUSH  = 4'd10;
    localparam logic [3:0] IC_POP   = 4'd11;

    // alu function codes
    localparam logic [3:0] ALU_ADD = 4'd0;
    localparam logic [3:0] ALU_SUB = 4'd1;
    localparam logic [3:0] ALU_AND = 4'd2;
    localparam logic [3:0] ALU_XOR = 4'd3;

    // condition codes
    localparam logic [3:0] C_ALWAYS = 4'd0;
    localparam logic [3:0] C_LE     = 4'd1;
    localparam logic [3:0] C_L      = 4'd2;
    localparam logic [3:0] C_E      = 4'd3;
    localparam logic [3:0] C_NE     = 4'd4;
    localparam logic [3:0] C_GE     = 4'd5;
    localparam logic [3:0] C_G      = 4'd6;

    // status codes
    localparam logic [1:0] STAT_AOK = 2'd0;
    localparam logic [1:0] STAT_HLT = 2'd1;
    localparam logic [1:0] STAT_ADR = 2'd2;
    localparam logic [1:0] STAT_INS = 2'd3;

    localparam logic [3:0] REG_NONE = 4'd15;

    // stack pointer steps
    localparam logic [63:0] STACK_DOWN = 64'hFFFF_FFFF_FFFF_FFF8;
    localparam logic [63:0] STACK_UP   = 64'd8;

    typedef struct packed {
        logic [1:0]  in_status;
        logic [3:0]  func;
        logic [3:0]  variant;
        logic [63:0] in_val_a;
        logic [63:0] in_val_b;
        logic [63:0] in_val_c;
        logic [3:0]  in_dest_e;
        logic [3:0]  in_dest_m;
        logic [1:0]  mem_status;
        logic [1:0]  wb_status;
    } t_exe_in;

    typedef struct packed {
        logic [1:0]  out_status;
        logic [3:0]  out_icode;
        logic        cond_ok;
        logic [63:0] alu_result;
        logic [63:0] out_val_a;
        logic [3:0]  out_dest_e;
        logic [3:0]  out_dest_m;
        logic        bubbled;
        logic        zero_flag;
        logic        sign_flag;
        logic        overflow_flag;
    } t_exe_out;

    // condition flags
    typedef struct packed {
        logic zf;
        logic sf;
        logic of;
    } t_flags;

    localparam t_flags FLAGS_RESET = '{zf: 1'b1, sf: 1'b0, of: 1'b0};

endpackage

`default_nettype wire

>>> hdl/y86_execute_stage_top.sv
// ----------------------------------------------------------------------------
// y86_execute_stage_top
// y86-64 pipelined execute stage with held condition flags
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  input     in         i_in_valid / o_in_stall      i_in_data  (t_exe_in)
//  result    out        o_out_valid / i_out_stall    o_out_data (t_exe_out)
//
//  an item passes through the input register, then
//  the alu and condition logic into the result register
//  one item per cycle unless the output stalls; the flag register is the loop
//  synchronous active-low reset empties both registers and sets ZF=1 SF=0 OF=0
//  a stall on the result side holds the result register and back-pressures
//  the input side only once the input register is also full
// ----------------------------------------------------------------------------
`default_nettype none

`include "y86_execute_stage_top_assert.svh"

module y86_execute_stage_top (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire y86es_pkg::t_exe_in i_in_data,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output y86es_pkg::t_exe_out   o_out_data
);
    import y86es_pkg::*;

    logic     r_in_vld;
    t_exe_in  r_in;
    logic     r_out_vld;
    t_exe_out r_out;
    t_flags   r_flags;

    logic     out_adv;
    logic     in_adv;
    logic     move;
    t_exe_out res;
    t_flags   n_flags;

    // pipeline advance
    assign out_adv = !r_out_vld || !i_out_stall;
    assign in_adv  = !r_in_vld || out_adv;
    assign move    = r_in_vld && out_adv;

    assign o_in_stall  = !in_adv;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_adv) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // execute logic
    y86es_alu u_alu (
        .i_item   (r_in),
        .i_flags  (r_flags),
        .o_result (res),
        .o_flags  (n_flags)
    );

    // flags and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_flags   <= FLAGS_RESET;
        end else begin
            if (out_adv) begin
                r_out_vld <= r_in_vld;
            end
            if (move) begin
                r_flags <= n_flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= res;
        end
    end

    // checks
    `Y86ES_ASSERT_NOW(a_bubble_form, o_out_valid && o_out_data.bubbled,
        (o_out_data.out_icode == IC_NOP) && (o_out_data.out_dest_e == REG_NONE) &&
        (o_out_data.alu_result == 64'd0))
    `Y86ES_ASSERT_NOW(a_flags_match, o_out_valid,
        (o_out_data.zero_flag == r_flags.zf) && (o_out_data.sign_flag == r_flags.sf) &&
        (o_out_data.overflow_flag == r_flags.of))
    `Y86ES_ASSERT_NEXT(a_flags_hold, !move, $stable(r_flags))
    `Y86ES_ASSERT_NOW(a_stall_full, o_in_stall, r_in_vld && r_out_vld)

endmodule

`default_nettype wire

>>> hdl/y86es_alu.sv
// ----------------------------------------------------------------------------
// y86es_alu
// operand select, alu, flag update, condition check and bubble for one item
// ----------------------------------------------------------------------------
`default_nettype none

module y86es_alu (
    input  wire y86es_pkg::t_exe_in  i_item,
    input  wire y86es_pkg::t_flags   i_flags,
    output y86es_pkg::t_exe_out      o_result,
    output y86es_pkg::t_flags        o_flags
);
    import y86es_pkg::*;

    logic [63:0] alu_a;
    logic [63:0] alu_b;
    logic [3:0]  alu_fn;
    logic [63:0] val_e;
    logic        ovf;
    logic        bubble;
    logic        lt;
    logic        cnd;
    t_flags      flags_nx;

    // alu operand a
    always_comb begin
        case (i_item.func)
            IC_CMOV, IC_OPQ:             alu_a = i_item.in_val_a;
            IC_IRMOV, IC_RMMOV, IC_MRMOV: alu_a = i_item.in_val_c;
            IC_CALL, IC_PUSH:            alu_a = STACK_DOWN;
            IC_RET, IC_POP:              alu_a = STACK_UP;
            default:                     alu_a = '0;
        endcase
    end

    // alu operand b
    always_comb begin
        case (i_item.func)
            IC_RMMOV, IC_MRMOV, IC_OPQ, IC_CALL, IC_RET, IC_PUSH, IC_POP:
                alu_b = i_item.in_val_b;
            default:
                alu_b = '0;
        endcase
    end

    assign alu_fn = (i_item.func == IC_OPQ) ? i_item.variant : ALU_ADD;

    // alu and signed overflow
    always_comb begin
        case (alu_fn)
            ALU_ADD: begin
                val_e = alu_b + alu_a;
                ovf   = (alu_a[63] == alu_b[63]) && (val_e[63] != alu_a[63]);
            end
            ALU_SUB: begin
                val_e = alu_b - alu_a;
                ovf   = (alu_a[63] != alu_b[63]) && (val_e[63] != alu_b[63]);
            end
            ALU_AND: begin
                val_e = alu_a & alu_b;
                ovf   = 1'b0;
            end
            ALU_XOR: begin
                val_e = alu_a ^ alu_b;
                ovf   = 1'b0;
            end
            default: begin
                val_e = '0;
                ovf   = 1'b0;
            end
        endcase
    end

    // a later stage with an exception squashes this item
    assign bubble = (i_item.mem_status != STAT_AOK) || (i_item.wb_status != STAT_AOK);

    // flag update for opq
    always_comb begin
        flags_nx = i_flags;
        if ((i_item.func == IC_OPQ) && !bubble) begin
            flags_nx.zf = (val_e == '0);
            flags_nx.sf = val_e[63];
            flags_nx.of = ovf;
        end
    end

    assign o_flags = flags_nx;
    assign lt      = flags_nx.sf ^ flags_nx.of;

    // jump and cmov condition
    always_comb begin
        if ((i_item.func == IC_JXX) || (i_item.func == IC_CMOV)) begin
            case (i_item.variant)
                C_ALWAYS: cnd = 1'b1;
                C_LE:     cnd = lt | flags_nx.zf;
                C_L:      cnd = lt;
                C_E:      cnd = flags_nx.zf;
                C_NE:     cnd = ~flags_nx.zf;
                C_GE:     cnd = ~lt;
                C_G:      cnd = ~lt & ~flags_nx.zf;
                default:  cnd = 1'b0;
            endcase
        end else begin
            cnd = 1'b0;
        end
    end

    // result item, bubble or pass-through
    always_comb begin
        o_result.zero_flag     = flags_nx.zf;
        o_result.sign_flag     = flags_nx.sf;
        o_result.overflow_flag = flags_nx.of;
        if (bubble) begin
            o_result.out_status = STAT_AOK;
            o_result.out_icode  = IC_NOP;
            o_result.cond_ok    = 1'b0;
            o_result.alu_result = '0;
            o_result.out_val_a  = '0;
            o_result.out_dest_e = REG_NONE;
            o_result.out_dest_m = REG_NONE;
            o_result.bubbled    = 1'b1;
        end else begin
            o_result.out_status = i_item.in_status;
            o_result.out_icode  = i_item.func;
            o_result.cond_ok    = cnd;
            o_result.alu_result = val_e;
            o_result.out_val_a  = i_item.in_val_a;
            o_result.out_dest_e = ((i_item.func == IC_CMOV) && !cnd) ? REG_NONE
                                                                     : i_item.in_dest_e;
            o_result.out_dest_m = i_item.in_dest_m;
            o_result.bubbled    = 1'b0;
        end
    end

endmodule

`default_nettype wire
